// ===== design/dsa_pkg.sv =====
// Shared constants, types and controller/datapath interface structs for the scale aligner.
`timescale 1ns / 1ps

package dsa_pkg;

    localparam int WORD_W        = 32;
    localparam int WORDS         = 3;
    localparam int MAN_W         = WORD_W * WORDS;
    localparam int SCALE_W       = 5;
    localparam int DSA_MAX_SCALE = 28;

    // Divide-by-ten of a 36-bit partial dividend: q = (cur * DIV10_M) >> DIV10_SHIFT,
    // with DIV10_M = ceil(2^40 / 10), which is exact for every 36-bit dividend.
    localparam int REM_W       = 4;
    localparam int CUR_W       = REM_W + WORD_W;
    localparam int DIV10_W     = 37;
    localparam int DIV10_SHIFT = 40;
    localparam logic [DIV10_W-1:0] DIV10_M = 37'd109951162778;

    localparam int IDX_W = $clog2(WORDS);

    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_start;
        logic div_word;
        logic skip_step;
        logic out_load;
    } dsa_cmd_t;

    typedef struct packed {
        logic steps_zero;
        logic can_mul;
        logic hi_nonzero;
        logic div_last;
    } dsa_status_t;

endpackage

// ===== design/dsa_ctrl.sv =====
// Sequencer for the scale aligner: handshakes and the step-by-step command stream.
`timescale 1ns / 1ps

module dsa_ctrl
    import dsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  dsa_status_t st,
    output dsa_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (st.steps_zero)
                    state_next = S_FINISH;
                else if (st.can_mul)
                    cmd.mul_step = 1'b1;
                else if (st.hi_nonzero)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                    cmd.skip_step = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_word = 1'b1;
                if (st.div_last)
                    state_next = S_CHECK;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/dsa_datapath.sv =====
// Operand registers, times-ten and word-serial divide-by-ten units, and result registers.
`timescale 1ns / 1ps

module dsa_datapath
    import dsa_pkg::*;
#(
    parameter int MAX_SCALE = DSA_MAX_SCALE
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dsa_cmd_t           cmd,
    output dsa_status_t        st,
    input  logic [WORD_W-1:0]  a_lo,
    input  logic [WORD_W-1:0]  a_mid,
    input  logic [WORD_W-1:0]  a_hi,
    input  logic [SCALE_W-1:0] a_scale,
    input  logic               a_sign,
    input  logic [WORD_W-1:0]  b_lo,
    input  logic [WORD_W-1:0]  b_mid,
    input  logic [WORD_W-1:0]  b_hi,
    input  logic [SCALE_W-1:0] b_scale,
    input  logic               b_sign,
    output logic [WORD_W-1:0]  ra_lo,
    output logic [WORD_W-1:0]  ra_mid,
    output logic [WORD_W-1:0]  ra_hi,
    output logic [SCALE_W-1:0] ra_scale,
    output logic               ra_sign,
    output logic [WORD_W-1:0]  rb_lo,
    output logic [WORD_W-1:0]  rb_mid,
    output logic [WORD_W-1:0]  rb_hi,
    output logic [SCALE_W-1:0] rb_scale,
    output logic               rb_sign
);

    localparam logic [SCALE_W-1:0] MAX_SCALE_V = SCALE_W'(MAX_SCALE);

    // Working copies: "up" is the lower-scale operand, "dn" the higher-scale one.
    logic [WORDS-1:0][WORD_W-1:0] man_up_reg;
    logic [WORDS-1:0][WORD_W-1:0] man_dn_reg;
    logic [SCALE_W-1:0]           scl_up_reg;
    logic [SCALE_W-1:0]           scl_dn_reg;
    logic [SCALE_W-1:0]           steps_reg;
    logic                         a_is_dn_reg;
    logic                         sign_a_reg;
    logic                         sign_b_reg;
    logic [REM_W-1:0]             rem_reg;
    logic [IDX_W-1:0]             idx_reg;

    logic [WORDS-1:0][WORD_W-1:0] ra_man_reg;
    logic [WORDS-1:0][WORD_W-1:0] rb_man_reg;
    logic [SCALE_W-1:0]           ra_scale_reg;
    logic [SCALE_W-1:0]           rb_scale_reg;
    logic                         ra_sign_reg;
    logic                         rb_sign_reg;

    logic                         a_is_dn;
    logic [MAN_W+3:0]             times10;
    logic                         fits;
    logic [CUR_W-1:0]             cur;
    logic [CUR_W+DIV10_W-1:0]     prod;
    logic [WORD_W-1:0]            quot;
    logic [REM_W-1:0]             rem_next;

    assign a_is_dn = (a_scale > b_scale);

    // 10*m = 8*m + 2*m; it fits when nothing lands above bit 95.
    assign times10 = {1'b0, man_up_reg, 3'b000} + {3'b000, man_up_reg, 1'b0};
    assign fits    = (times10[MAN_W+3:MAN_W] == 4'd0);

    // One word of the long division by ten, most significant word first.
    assign cur      = {rem_reg, man_dn_reg[idx_reg]};
    assign prod     = (CUR_W+DIV10_W)'(cur) * (CUR_W+DIV10_W)'(DIV10_M);
    assign quot     = prod[DIV10_SHIFT +: WORD_W];
    assign rem_next = cur[REM_W-1:0] - {quot[0], 3'b000} - {quot[2:0], 1'b0};

    assign st.steps_zero = (steps_reg == '0);
    assign st.can_mul    = fits && (scl_up_reg < MAX_SCALE_V);
    assign st.hi_nonzero = (scl_dn_reg != '0);
    assign st.div_last   = (idx_reg == '0);

    always_ff @(posedge clk)
    begin
        priority if (cmd.load)
        begin
            a_is_dn_reg <= a_is_dn;
            sign_a_reg  <= a_sign;
            sign_b_reg  <= b_sign;
            if (a_is_dn)
            begin
                man_dn_reg <= {a_hi, a_mid, a_lo};
                man_up_reg <= {b_hi, b_mid, b_lo};
                scl_dn_reg <= a_scale;
                scl_up_reg <= b_scale;
                steps_reg  <= a_scale - b_scale;
            end
            else
            begin
                man_dn_reg <= {b_hi, b_mid, b_lo};
                man_up_reg <= {a_hi, a_mid, a_lo};
                scl_dn_reg <= b_scale;
                scl_up_reg <= a_scale;
                steps_reg  <= b_scale - a_scale;
            end
        end
        else if (cmd.mul_step)
        begin
            man_up_reg <= times10[MAN_W-1:0];
            scl_up_reg <= scl_up_reg + 1'b1;
            steps_reg  <= steps_reg - 1'b1;
        end
        else if (cmd.div_start)
        begin
            rem_reg <= '0;
            idx_reg <= IDX_W'(WORDS - 1);
        end
        else if (cmd.div_word)
        begin
            man_dn_reg[idx_reg] <= quot;
            rem_reg             <= rem_next;
            idx_reg             <= idx_reg - 1'b1;
            if (idx_reg == '0)
            begin
                scl_dn_reg <= scl_dn_reg - 1'b1;
                steps_reg  <= steps_reg - 1'b1;
            end
        end
        else if (cmd.skip_step)
        begin
            steps_reg <= steps_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            ra_sign_reg <= sign_a_reg;
            rb_sign_reg <= sign_b_reg;
            if (a_is_dn_reg)
            begin
                ra_man_reg   <= man_dn_reg;
                ra_scale_reg <= scl_dn_reg;
                rb_man_reg   <= man_up_reg;
                rb_scale_reg <= scl_up_reg;
            end
            else
            begin
                ra_man_reg   <= man_up_reg;
                ra_scale_reg <= scl_up_reg;
                rb_man_reg   <= man_dn_reg;
                rb_scale_reg <= scl_dn_reg;
            end
        end
    end

    assign ra_lo    = ra_man_reg[0];
    assign ra_mid   = ra_man_reg[1];
    assign ra_hi    = ra_man_reg[2];
    assign ra_scale = ra_scale_reg;
    assign ra_sign  = ra_sign_reg;
    assign rb_lo    = rb_man_reg[0];
    assign rb_mid   = rb_man_reg[1];
    assign rb_hi    = rb_man_reg[2];
    assign rb_scale = rb_scale_reg;
    assign rb_sign  = rb_sign_reg;

`ifndef SYNTHESIS
    // Each step closes the scale gap by one, so the remaining count tracks the gap.
    a_steps_track: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_step |-> (steps_reg == scl_dn_reg - scl_up_reg))
        else $error("step count out of step with scale gap");

    a_mul_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_step |=> (scl_up_reg <= MAX_SCALE_V))
        else $error("lower scale raised past its limit");

    a_div_idx: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_word |-> (idx_reg < IDX_W'(WORDS)))
        else $error("divider word index out of range");

    a_div_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (steps_reg != '0))
        else $error("division started with no step left");

    a_scales_meet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (ra_scale_reg == rb_scale_reg))
        else $error("result scales differ");
`endif

endmodule

// ===== design/decimal_scale_align_96bit.sv =====
// Top level of the 96-bit decimal scale aligner.
`timescale 1ns / 1ps

// Brings two decimals (96-bit mantissa, scale, sign) to a common scale. One request
// is worked on at a time, through m multiply-by-ten steps on the lower-scale
// operand and v divide-by-ten steps on the higher-scale one, with
// m + v equal to the scale difference (at most 31 steps). The divide-by-ten
// unit handles one 32-bit word per cycle through a reciprocal multiply. The result
// sits in its own register, so the next request may be accepted while it waits.
module decimal_scale_align_96bit
    import dsa_pkg::*;
#(
    parameter int MAX_SCALE = DSA_MAX_SCALE
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [WORD_W-1:0]  a_lo,
    input  logic [WORD_W-1:0]  a_mid,
    input  logic [WORD_W-1:0]  a_hi,
    input  logic [SCALE_W-1:0] a_scale,
    input  logic               a_sign,
    input  logic [WORD_W-1:0]  b_lo,
    input  logic [WORD_W-1:0]  b_mid,
    input  logic [WORD_W-1:0]  b_hi,
    input  logic [SCALE_W-1:0] b_scale,
    input  logic               b_sign,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [WORD_W-1:0]  ra_lo,
    output logic [WORD_W-1:0]  ra_mid,
    output logic [WORD_W-1:0]  ra_hi,
    output logic [SCALE_W-1:0] ra_scale,
    output logic               ra_sign,
    output logic [WORD_W-1:0]  rb_lo,
    output logic [WORD_W-1:0]  rb_mid,
    output logic [WORD_W-1:0]  rb_hi,
    output logic [SCALE_W-1:0] rb_scale,
    output logic               rb_sign
);

    dsa_cmd_t    cmd;
    dsa_status_t st;

    dsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    dsa_datapath #(
        .MAX_SCALE (MAX_SCALE)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .a_lo     (a_lo),
        .a_mid    (a_mid),
        .a_hi     (a_hi),
        .a_scale  (a_scale),
        .a_sign   (a_sign),
        .b_lo     (b_lo),
        .b_mid    (b_mid),
        .b_hi     (b_hi),
        .b_scale  (b_scale),
        .b_sign   (b_sign),
        .ra_lo    (ra_lo),
        .ra_mid   (ra_mid),
        .ra_hi    (ra_hi),
        .ra_scale (ra_scale),
        .ra_sign  (ra_sign),
        .rb_lo    (rb_lo),
        .rb_mid   (rb_mid),
        .rb_hi    (rb_hi),
        .rb_scale (rb_scale),
        .rb_sign  (rb_sign)
    );

endmodule

// ===== sim/decimal_scale_align_96bit_tb.sv =====
// Self-checking testbench for the 96-bit decimal scale aligner.
`timescale 1ns / 1ps

module decimal_scale_align_96bit_tb;
    import dsa_pkg::*;

    typedef struct {
        logic [MAN_W-1:0]   a_man;
        logic [SCALE_W-1:0] a_scale;
        logic               a_sign;
        logic [MAN_W-1:0]   b_man;
        logic [SCALE_W-1:0] b_scale;
        logic               b_sign;
    } decimal_pair_t;

    // Largest mantissa that can still be multiplied by ten within 96 bits.
    localparam logic [MAN_W-1:0] FIT_LIMIT = 96'h1999_9999_9999_9999_9999_9999;
    localparam int RANDOM_REQUESTS = 750;

    class align_scoreboard;
        decimal_pair_t pending_results[$];
        int            errors = 0;

        function decimal_pair_t aligned_pair(decimal_pair_t req);
            logic [MAN_W-1:0]   man [2];
            logic [SCALE_W-1:0] scl [2];
            logic [MAN_W+3:0]   prod;
            decimal_pair_t      res;
            int                 upper;
            int                 lower;
            int                 diff;
            man[0] = req.a_man;
            man[1] = req.b_man;
            scl[0] = req.a_scale;
            scl[1] = req.b_scale;
            if (scl[0] > scl[1])
            begin
                upper = 0;
                lower = 1;
            end
            else
            begin
                upper = 1;
                lower = 0;
            end
            diff = int'(scl[upper]) - int'(scl[lower]);
            for (int s = 0; s < diff; s++)
            begin
                prod = {4'b0, man[lower]} * 10;
                if (prod[MAN_W+3:MAN_W] == 4'b0 && scl[lower] < DSA_MAX_SCALE)
                begin
                    man[lower] = prod[MAN_W-1:0];
                    scl[lower] = scl[lower] + 1'b1;
                end
                else if (scl[upper] != 0)
                begin
                    man[upper] = man[upper] / 10;
                    scl[upper] = scl[upper] - 1'b1;
                end
            end
            res = req;
            res.a_man   = man[0];
            res.b_man   = man[1];
            res.a_scale = scl[0];
            res.b_scale = scl[1];
            return res;
        endfunction

        function void note_request(decimal_pair_t req);
            pending_results.push_back(aligned_pair(req));
        endfunction

        function void compare(string name, logic [MAN_W-1:0] want, logic [MAN_W-1:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(decimal_pair_t got);
            decimal_pair_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no request outstanding, a=%0h b=%0h",
                         $time, got.a_man, got.b_man);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare("ra_lo",    want.a_man[31:0],  got.a_man[31:0]);
            compare("ra_mid",   want.a_man[63:32], got.a_man[63:32]);
            compare("ra_hi",    want.a_man[95:64], got.a_man[95:64]);
            compare("ra_scale", want.a_scale,      got.a_scale);
            compare("ra_sign",  want.a_sign,       got.a_sign);
            compare("rb_lo",    want.b_man[31:0],  got.b_man[31:0]);
            compare("rb_mid",   want.b_man[63:32], got.b_man[63:32]);
            compare("rb_hi",    want.b_man[95:64], got.b_man[95:64]);
            compare("rb_scale", want.b_scale,      got.b_scale);
            compare("rb_sign",  want.b_sign,       got.b_sign);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [WORD_W-1:0]  a_lo, a_mid, a_hi;
    logic [SCALE_W-1:0] a_scale;
    logic               a_sign;
    logic [WORD_W-1:0]  b_lo, b_mid, b_hi;
    logic [SCALE_W-1:0] b_scale;
    logic               b_sign;
    logic               out_valid;
    logic               out_ready;
    logic [WORD_W-1:0]  ra_lo, ra_mid, ra_hi;
    logic [SCALE_W-1:0] ra_scale;
    logic               ra_sign;
    logic [WORD_W-1:0]  rb_lo, rb_mid, rb_hi;
    logic [SCALE_W-1:0] rb_scale;
    logic               rb_sign;

    align_scoreboard sb = new();
    bit              calm;

    decimal_scale_align_96bit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a_lo      (a_lo),
        .a_mid     (a_mid),
        .a_hi      (a_hi),
        .a_scale   (a_scale),
        .a_sign    (a_sign),
        .b_lo      (b_lo),
        .b_mid     (b_mid),
        .b_hi      (b_hi),
        .b_scale   (b_scale),
        .b_sign    (b_sign),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ra_lo     (ra_lo),
        .ra_mid    (ra_mid),
        .ra_hi     (ra_hi),
        .ra_scale  (ra_scale),
        .ra_sign   (ra_sign),
        .rb_lo     (rb_lo),
        .rb_mid    (rb_mid),
        .rb_hi     (rb_hi),
        .rb_scale  (rb_scale),
        .rb_sign   (rb_sign)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 30);
    endfunction

    function automatic logic [MAN_W-1:0] rand_mantissa();
        logic [MAN_W-1:0] full;
        full = {$urandom, $urandom, $urandom};
        unique case ($urandom_range(0, 5))
            0: return full;
            1: return MAN_W'($urandom_range(0, 1000));
            2: return {32'b0, full[63:0]};
            3: return FIT_LIMIT + MAN_W'($urandom_range(0, 40)) - MAN_W'(20);
            4: return $urandom_range(0, 1) ? '0 : '1;
            default: return full >> $urandom_range(0, 95);
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] rand_scale();
        if ($urandom_range(0, 99) < 8)
            return SCALE_W'($urandom_range(29, 31));
        return SCALE_W'($urandom_range(0, DSA_MAX_SCALE));
    endfunction

    function automatic decimal_pair_t make_pair(logic [MAN_W-1:0] am, int asc, int asg,
                                                logic [MAN_W-1:0] bm, int bsc, int bsg);
        decimal_pair_t p;
        p.a_man   = am;
        p.a_scale = SCALE_W'(asc);
        p.a_sign  = 1'(asg);
        p.b_man   = bm;
        p.b_scale = SCALE_W'(bsc);
        p.b_sign  = 1'(bsg);
        return p;
    endfunction

    // Entered right after a rising edge; returns at the edge that accepts the request.
    task automatic send_request(decimal_pair_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        a_lo     <= req.a_man[31:0];
        a_mid    <= req.a_man[63:32];
        a_hi     <= req.a_man[95:64];
        a_scale  <= req.a_scale;
        a_sign   <= req.a_sign;
        b_lo     <= req.b_man[31:0];
        b_mid    <= req.b_man[63:32];
        b_hi     <= req.b_man[95:64];
        b_scale  <= req.b_scale;
        b_sign   <= req.b_sign;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(req);
    endtask

    // Result side: checks every accepted result and stalls at random.
    initial
    begin
        int            hold;
        int            r;
        decimal_pair_t got;
        hold      = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.a_man   = {ra_hi, ra_mid, ra_lo};
                got.a_scale = ra_scale;
                got.a_sign  = ra_sign;
                got.b_man   = {rb_hi, rb_mid, rb_lo};
                got.b_scale = rb_scale;
                got.b_sign  = rb_sign;
                sb.check_result(got);
            end
            if (hold > 0)
                hold--;
            else if (calm)
                out_ready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    out_ready <= 1'b1;
                    hold = $urandom_range(0, 5);
                end
                else
                begin
                    out_ready <= 1'b0;
                    hold = (r < 92) ? $urandom_range(0, 3) : $urandom_range(10, 30);
                end
            end
        end
    end

    initial
    begin
        decimal_pair_t directed [$];
        in_valid  = 1'b0;
        {a_lo, a_mid, a_hi, a_scale, a_sign} = '0;
        {b_lo, b_mid, b_hi, b_scale, b_sign} = '0;
        calm  = 1'b1;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Equal scales pass through, including all-ones and raw scales above the limit.
        directed.push_back(make_pair('0, 0, 0, '0, 0, 0));
        directed.push_back(make_pair('1, 28, 1, '1, 28, 1));
        directed.push_back(make_pair(96'd12345, 31, 0, 96'd678, 31, 1));
        // Lower operand cannot grow, so the higher one is divided all the way down.
        directed.push_back(make_pair('1, 0, 1, '1, 28, 0));
        directed.push_back(make_pair('1, 0, 0, '1, 31, 1));
        // Lower operand grows through every step.
        directed.push_back(make_pair(96'd1, 0, 0, 96'd1, 28, 0));
        directed.push_back(make_pair(96'd7, 28, 1, '0, 0, 1));
        // Exact fit boundary of the multiply, from both sides.
        directed.push_back(make_pair(FIT_LIMIT, 3, 0, '1, 4, 1));
        directed.push_back(make_pair(FIT_LIMIT + 1'b1, 3, 1, '1, 4, 0));
        directed.push_back(make_pair('1, 9, 0, FIT_LIMIT, 8, 1));
        // Carry out of the middle word is what makes this one overflow.
        directed.push_back(make_pair({32'h1999_9999, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 2, 0,
                                     96'd99, 3, 0));
        directed.push_back(make_pair({32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0, 1,
                                     96'd5, 5, 0));
        // Lower scale above the limit is never multiplied.
        directed.push_back(make_pair(96'd3, 29, 0, '1, 30, 1));
        directed.push_back(make_pair(96'd3, 31, 1, 96'd3, 0, 0));
        directed.push_back(make_pair(96'd10, 5, 0, 96'd10, 2, 1));
        directed.push_back(make_pair(96'd10, 2, 1, 96'd10, 5, 0));
        directed.push_back(make_pair('1, 27, 1, '1, 28, 1));
        directed.push_back(make_pair({32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 17, 1,
                                     {32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}, 4, 0));

        foreach (directed[i])
            send_request(directed[i]);

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            calm = (i < 100) || (i >= 400 && i < 460);
            send_request(make_pair(rand_mantissa(), int'(rand_scale()),
                                   int'($urandom_range(0, 1)),
                                   rand_mantissa(), int'(rand_scale()),
                                   int'($urandom_range(0, 1))));
        end
        in_valid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        // Long enough to catch a stray result after the last expected one.
        repeat (140) @(posedge clk);

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("[decimal_scale_align_96bit] OK");
        else
            $display("[decimal_scale_align_96bit] ERROR");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("[decimal_scale_align_96bit] ERROR");
        $finish;
    end

endmodule
